// ===== design/crc16fc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16fc_pkg
// Shared types, constants and the byte-wide CRC-16/CCITT-FALSE update.
// ----------------------------------------------------------------------------
package crc16fc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int          CRC_TOP  = 15;

    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int RESULT_W = 34;
    localparam int M_DATA_W = 40;

    // held_count codes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;
    localparam logic [1:0] HELD_FULL = 2'd3;

    // packed low bit first: frame_ok, too_short, computed_crc, received_crc
    typedef struct packed {
        logic [CRC_W-1:0] received_crc;
        logic [CRC_W-1:0] computed_crc;
        logic             too_short;
        logic             frame_ok;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] data;
    } beat_t;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_TOP]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/crc16fc_in_stage.sv =====
// ----------------------------------------------------------------------------
// crc16fc_in_stage
// Input register for the byte stream; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module crc16fc_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [crc16fc_pkg::BYTE_W-1:0]    s_tdata,  // [7:0] data_byte
    input  logic                              s_tlast,  // end_of_frame
    input  logic                              take,
    output crc16fc_pkg::beat_t                beat
);

    crc16fc_pkg::beat_t beat_reg;
    crc16fc_pkg::beat_t beat_next;

    assign s_tready = !beat_reg.valid || take;
    assign beat     = beat_reg;

    always_comb begin
        beat_next = beat_reg;
        if (s_tready) begin
            beat_next.valid = s_tvalid;
            beat_next.data  = s_tdata;
            beat_next.last  = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
        end else begin
            beat_reg.valid <= beat_next.valid;
        end
        beat_reg.data <= beat_next.data;
        beat_reg.last <= beat_next.last;
    end

endmodule

// ===== design/crc16fc_check.sv =====
// ----------------------------------------------------------------------------
// crc16fc_check
// Two-byte delay line, CRC accumulator and end-of-frame verdict.
// ----------------------------------------------------------------------------
module crc16fc_check (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  crc16fc_pkg::beat_t    beat,
    input  logic                  out_free,
    output logic                  take,
    output logic                  res_load,
    output crc16fc_pkg::result_t  res
);

    logic [crc16fc_pkg::CRC_W-1:0]  crc_reg, crc_next, crc_upd;
    logic [crc16fc_pkg::BYTE_W-1:0] held0_reg, held0_next, held0_upd;
    logic [crc16fc_pkg::BYTE_W-1:0] held1_reg, held1_next, held1_upd;
    logic [1:0]                     count_reg, count_next, count_upd;

    assign take     = beat.valid && (!beat.last || out_free);
    assign res_load = take && beat.last;

    always_comb begin
        crc_upd   = crc_reg;
        held0_upd = held0_reg;
        held1_upd = held1_reg;
        if (count_reg == crc16fc_pkg::HELD_TWO || count_reg == crc16fc_pkg::HELD_FULL) begin
            crc_upd   = crc16fc_pkg::crc_feed(crc_reg, held0_reg);
            held0_upd = held1_reg;
            held1_upd = beat.data;
            count_upd = crc16fc_pkg::HELD_FULL;
        end else begin
            if (count_reg[0]) begin
                held1_upd = beat.data;
            end else begin
                held0_upd = beat.data;
            end
            count_upd = count_reg + 2'd1;
        end

        res.received_crc = {held1_upd, held0_upd};
        res.computed_crc = crc_upd;
        res.too_short    = (count_upd != crc16fc_pkg::HELD_FULL);
        res.frame_ok     = !res.too_short && (res.received_crc == crc_upd);

        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        if (take) begin
            if (beat.last) begin
                crc_next   = crc16fc_pkg::CRC_INIT;
                held0_next = '0;
                held1_next = '0;
                count_next = crc16fc_pkg::HELD_NONE;
            end else begin
                crc_next   = crc_upd;
                held0_next = held0_upd;
                held1_next = held1_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= crc16fc_pkg::CRC_INIT;
            held0_reg <= '0;
            held1_reg <= '0;
            count_reg <= crc16fc_pkg::HELD_NONE;
        end else begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/crc16fc_out_stage.sv =====
// ----------------------------------------------------------------------------
// crc16fc_out_stage
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
module crc16fc_out_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                res_load,
    input  crc16fc_pkg::result_t                res,
    output logic                                out_free,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] frame_ok, [1] too_short, [17:2] computed_crc, [33:18] received_crc
    output logic [crc16fc_pkg::M_DATA_W-1:0]    m_tdata
);

    logic                 valid_reg, valid_next;
    crc16fc_pkg::result_t res_reg, res_next;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(crc16fc_pkg::M_DATA_W - crc16fc_pkg::RESULT_W){1'b0}}, res_reg};

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (res_load) begin
            valid_next = 1'b1;
            res_next   = res;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

endmodule

// ===== design/crc16_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_checker_top
// CRC-16/CCITT-FALSE frame checker over a byte stream with a last flag.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle, as the 8-bit CRC update is combinational;
// a last beat waits while the result register holds a result that m_tready has not taken.
// Result path: input register, then result register, which drives m_tvalid.
// Reset: aresetn low for one edge empties both registers, sets the CRC to 0xFFFF
// and clears the delay line.
module crc16_frame_checker_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [crc16fc_pkg::BYTE_W-1:0]      s_tdata,  // [7:0] data_byte
    input  logic                                s_tlast,  // end_of_frame
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] frame_ok, [1] too_short, [17:2] computed_crc, [33:18] received_crc
    output logic [crc16fc_pkg::M_DATA_W-1:0]    m_tdata
);

    crc16fc_pkg::beat_t   beat;
    crc16fc_pkg::result_t res;
    logic                 take;
    logic                 res_load;
    logic                 out_free;

    crc16fc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .beat     (beat)
    );

    crc16fc_check u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat     (beat),
        .out_free (out_free),
        .take     (take),
        .res_load (res_load),
        .res      (res)
    );

    crc16fc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (res_load),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
